// ----- hw/rtl/vssm_pkg.sv -----
// Shared constants and types for the voice slot sample mixer.
package vssm_pkg;

    // Sizes of the voice table and the sample memory
    localparam int VOICES       = 30;
    localparam int SAMPLE_WORDS = 4096;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 13;

    // Voice index and sequencer counter widths
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // One voice table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  remaining;
    } voice_t;

endpackage

// ----- hw/rtl/voice_slot_sample_mixer_unit.sv -----
// Top level of the voice slot sample mixer: sample memory, voice table and tick sequencer.
//
// A load item writes one signed 16-bit word into the 4096-word sample memory, and a queue
// item places a sound (start address, length) into the lowest free of the 30 voice slots,
// reporting queue_full when none is free; both give their result at the next edge. A tick
// item walks the voice table one slot per cycle, since the table has a single read port and
// is a synchronous memory, and runs a three-stage read/modify/write pipeline (table read,
// sample read plus table write-back, saturating add) to form its result. Exactly one
// result comes out for every item, held in an output register; a new item is taken once
// the block is idle and that register is free or being emptied. Sample words that were
// never loaded read as unknown values.
module voice_slot_sample_mixer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [vssm_pkg::KIND_W-1:0]         kind,
    input  logic [vssm_pkg::ADDR_W-1:0]         load_address,
    input  logic signed [vssm_pkg::SAMPLE_W-1:0] load_value,
    input  logic [vssm_pkg::ADDR_W-1:0]         sound_start,
    input  logic [vssm_pkg::LEN_W-1:0]          sound_length,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [vssm_pkg::SAMPLE_W-1:0] mixed_sample,
    output logic                                sample_valid,
    output logic                                queue_accepted,
    output logic                                queue_full
);
    import vssm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       s1_vld_reg, s1_vld_next;
    logic [VIDX_W-1:0]          s1_idx_reg, s1_idx_next;
    logic                       s2_vld_reg, s2_vld_next;
    logic                       s2_act_reg, s2_act_next;
    logic signed [SAMPLE_W-1:0] mix_reg, mix_next;
    logic [VOICES-1:0]          active_reg, active_next;

    logic                       result_valid_reg, result_valid_next;
    logic signed [SAMPLE_W-1:0] mixed_sample_reg, mixed_sample_next;
    logic                       sample_valid_reg, sample_valid_next;
    logic                       queue_accepted_reg, queue_accepted_next;
    logic                       queue_full_reg, queue_full_next;

    // Memories and their ports
    logic [SAMPLE_W-1:0]        sample_mem [SAMPLE_WORDS];
    logic [SAMPLE_W-1:0]        smp_rdata_reg;
    logic                       smp_we;
    voice_t                     voice_mem [VOICES];
    voice_t                     voice_rdata_reg;
    logic [VIDX_W-1:0]          vt_raddr;
    logic                       vt_we;
    logic [VIDX_W-1:0]          vt_waddr;
    voice_t                     vt_wdata;

    logic                       accept;
    logic                       queue_take;
    logic                       free_found;
    logic [VIDX_W-1:0]          free_idx;
    logic                       s1_act;
    logic [LEN_W-1:0]           rem_dec;
    logic [ADDR_W-1:0]          addr_inc;
    logic signed [SAMPLE_W:0]   sum_wide;
    logic signed [SAMPLE_W-1:0] sum_sat;
    logic                       tick_done;

    // Handshake
    assign item_ready = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    // Find the lowest free voice slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(i);
            end
        end
    end

    assign queue_take = accept && (kind == KIND_QUEUE) && (sound_length != '0) && free_found;
    assign smp_we     = accept && (kind == KIND_LOAD);

    // Stage one: advance the voice whose table entry just came out of memory
    assign s1_act   = s1_vld_reg && active_reg[s1_idx_reg];
    assign rem_dec  = voice_rdata_reg.remaining - LEN_W'(1);
    assign addr_inc = (voice_rdata_reg.addr == ADDR_W'(SAMPLE_WORDS - 1)) ? '0
                    : voice_rdata_reg.addr + ADDR_W'(1);

    // Stage two: add the fetched sample and clamp to the 16-bit range
    assign sum_wide = {mix_reg[SAMPLE_W-1], mix_reg}
                    + {smp_rdata_reg[SAMPLE_W-1], smp_rdata_reg};
    always_comb
    begin
        if (sum_wide[SAMPLE_W] == sum_wide[SAMPLE_W-1])
            sum_sat = sum_wide[SAMPLE_W-1:0];
        else if (sum_wide[SAMPLE_W])
            sum_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        else
            sum_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end

    // Voice table write port: a new sound when idle, the write-back while ticking
    always_comb
    begin
        vt_we    = 1'b0;
        vt_waddr = s1_idx_reg;
        vt_wdata = '{addr: addr_inc, remaining: rem_dec};
        if (queue_take)
        begin
            vt_we    = 1'b1;
            vt_waddr = free_idx;
            vt_wdata = '{addr: sound_start, remaining: sound_length};
        end
        else if (s1_act)
        begin
            vt_we = 1'b1;
        end
    end

    assign vt_raddr  = rd_idx_reg[VIDX_W-1:0];
    assign tick_done = (rd_idx_reg == CNT_W'(VOICES)) && !s1_vld_reg && !s2_vld_reg;

    // Active bits: set on a new sound, drop once the last sample is played
    always_comb
    begin
        active_next = active_reg;
        if (queue_take)
            active_next[free_idx] = 1'b1;
        if (s1_act && (rem_dec == '0))
            active_next[s1_idx_reg] = 1'b0;
    end

    // Control and result register
    always_comb
    begin
        state_next          = state_reg;
        rd_idx_next         = rd_idx_reg;
        s1_vld_next         = 1'b0;
        s1_idx_next         = s1_idx_reg;
        s2_vld_next         = 1'b0;
        s2_act_next         = 1'b0;
        mix_next            = mix_reg;
        result_valid_next   = result_valid_reg && !result_ready;
        mixed_sample_next   = mixed_sample_reg;
        sample_valid_next   = sample_valid_reg;
        queue_accepted_next = queue_accepted_reg;
        queue_full_next     = queue_full_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mixed_sample_next   = '0;
                    sample_valid_next   = 1'b0;
                    queue_accepted_next = 1'b0;
                    queue_full_next     = 1'b0;
                    priority if (kind == KIND_TICK)
                    begin
                        state_next  = ST_TICK;
                        rd_idx_next = '0;
                        mix_next    = '0;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        if (kind == KIND_QUEUE && sound_length != '0)
                        begin
                            queue_accepted_next = free_found;
                            queue_full_next     = !free_found;
                        end
                    end
                end
            end
            ST_TICK:
            begin
                // Issue one table read per cycle
                if (rd_idx_reg != CNT_W'(VOICES))
                begin
                    s1_vld_next = 1'b1;
                    s1_idx_next = rd_idx_reg[VIDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                s2_vld_next = s1_vld_reg;
                s2_act_next = s1_act;
                if (s2_vld_reg && s2_act_reg)
                    mix_next = sum_sat;
                if (tick_done)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                    mixed_sample_next = mix_reg;
                    sample_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_idx_reg       <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s2_act_reg       <= 1'b0;
            active_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_idx_reg       <= rd_idx_next;
            s1_vld_reg       <= s1_vld_next;
            s2_vld_reg       <= s2_vld_next;
            s2_act_reg       <= s2_act_next;
            active_reg       <= active_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg         <= s1_idx_next;
        mix_reg            <= mix_next;
        mixed_sample_reg   <= mixed_sample_next;
        sample_valid_reg   <= sample_valid_next;
        queue_accepted_reg <= queue_accepted_next;
        queue_full_reg     <= queue_full_next;
    end

    // Sample memory: load writes, playback reads
    always_ff @(posedge clk)
    begin
        if (smp_we)
            sample_mem[load_address] <= load_value;
        smp_rdata_reg <= sample_mem[voice_rdata_reg.addr];
    end

    // Voice table memory
    always_ff @(posedge clk)
    begin
        if (vt_we)
            voice_mem[vt_waddr] <= vt_wdata;
        voice_rdata_reg <= voice_mem[vt_raddr];
    end

    // Outputs
    assign result_valid   = result_valid_reg;
    assign mixed_sample   = mixed_sample_reg;
    assign sample_valid   = sample_valid_reg;
    assign queue_accepted = queue_accepted_reg;
    assign queue_full     = queue_full_reg;

endmodule

// ----- hw/rtl/vssm_checker.sv -----
// Port-level checker for the voice slot sample mixer, with its bind statement.
module vssm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_valid,
    input logic                                 item_ready,
    input logic [vssm_pkg::KIND_W-1:0]          kind,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [vssm_pkg::SAMPLE_W-1:0] mixed_sample,
    input logic                                 sample_valid,
    input logic                                 queue_accepted,
    input logic                                 queue_full
);
    import vssm_pkg::*;

    // At most one status flag per result item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $countones({sample_valid, queue_accepted, queue_full}) <= 1)
        else $error("more than one status flag set on a result item");

    // Only a tick carries a mix value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !sample_valid |-> mixed_sample == '0)
        else $error("non-tick result carries a nonzero mix");

    // A tick holds off further items while the voices are walked
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && kind == KIND_TICK |=> !item_ready)
        else $error("item taken right after a tick item");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(mixed_sample)
            && $stable(sample_valid) && $stable(queue_accepted) && $stable(queue_full))
        else $error("stalled result item changed");

endmodule

bind voice_slot_sample_mixer_unit vssm_checker u_vssm_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the voice slot sample mixer: planned stimulus, driver and monitor.
`timescale 1ns / 1ps

module testbench;
    import vssm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int ITEM_TARGET    = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    // Kind that the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Two copies of the mixer state: one steers the plan, one tracks accepted items
    typedef enum int {PLAN_COPY = 0, LIVE_COPY = 1} state_copy_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   load_address;
        logic [SAMPLE_W-1:0] load_value;
        logic [ADDR_W-1:0]   sound_start;
        logic [LEN_W-1:0]    sound_length;
    } mixer_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mixed_sample;
        logic                sample_valid;
        logic                queue_accepted;
        logic                queue_full;
    } mixer_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [KIND_W-1:0] kind = '0;
    logic [ADDR_W-1:0] load_address = '0;
    logic signed [SAMPLE_W-1:0] load_value = '0;
    logic [ADDR_W-1:0] sound_start = '0;
    logic [LEN_W-1:0] sound_length = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic sample_valid;
    logic queue_accepted;
    logic queue_full;

    // Mixer state, one set per copy
    logic [SAMPLE_W-1:0] sample_words [2][SAMPLE_WORDS];
    bit                  voice_on     [2][VOICES];
    logic [ADDR_W-1:0]   voice_addr   [2][VOICES];
    logic [LEN_W-1:0]    voice_left   [2][VOICES];
    bit                  word_loaded  [SAMPLE_WORDS];

    mixer_item_t  item_backlog [$];
    mixer_reply_t predicted_replies [$];
    mixer_item_t  offered_item;

    int planned_total;
    int noise_items;
    int items_taken;
    int mismatches;
    int quiet_cycles;
    int hold_left;
    bit hold_done;
    int ticks_seen;
    int clamps_seen;
    int queued_seen;
    int full_seen;
    logic [ADDR_W-1:0] last_base;

    voice_slot_sample_mixer_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .kind           (kind),
        .load_address   (load_address),
        .load_value     (load_value),
        .sound_start    (sound_start),
        .sound_length   (sound_length),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .mixed_sample   (mixed_sample),
        .sample_valid   (sample_valid),
        .queue_accepted (queue_accepted),
        .queue_full     (queue_full)
    );

    always #HALF_PERIOD clk = ~clk;

    // Apply one item to a state copy and return the reply it earns
    function automatic mixer_reply_t mix_apply(input state_copy_t c, input mixer_item_t it);
        mixer_reply_t r;
        int sum;
        int v;
        int slot;
        logic signed [SAMPLE_W-1:0] word;
        r = '0;
        case (it.kind)
            KIND_LOAD:
            begin
                sample_words[c][it.load_address] = it.load_value;
            end
            KIND_QUEUE:
            begin
                if (it.sound_length != 0)
                begin
                    slot = -1;
                    for (v = 0; v < VOICES; v++)
                        if (!voice_on[c][v] && slot < 0)
                            slot = v;
                    if (slot >= 0)
                    begin
                        voice_on[c][slot]   = 1'b1;
                        voice_addr[c][slot] = it.sound_start;
                        voice_left[c][slot] = it.sound_length;
                        r.queue_accepted    = 1'b1;
                    end
                    else
                        r.queue_full = 1'b1;
                end
            end
            KIND_TICK:
            begin
                r.sample_valid = 1'b1;
                sum = 0;
                for (v = 0; v < VOICES; v++)
                begin
                    if (voice_on[c][v])
                    begin
                        // add, clamp, then advance the voice
                        word = sample_words[c][voice_addr[c][v]];
                        sum = sum + int'(word);
                        if (sum > 32767)
                            sum = 32767;
                        if (sum < -32768)
                            sum = -32768;
                        voice_addr[c][v] = voice_addr[c][v] + 1'b1;
                        if (voice_left[c][v] != 0)
                            voice_left[c][v] = voice_left[c][v] - 1'b1;
                        if (voice_left[c][v] == 0)
                            voice_on[c][v] = 1'b0;
                    end
                end
                r.mixed_sample = sum[SAMPLE_W-1:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Sample values lean toward the extremes so the clamp gets exercised
    function automatic logic [SAMPLE_W-1:0] rnd_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 16'h7FFF;
        else if (pick < 16)
            return 16'h8000;
        else if (pick < 20)
            return 16'hFFFF;
        else if (pick < 24)
            return 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    // Mostly short sounds, now and then any length the field allows
    function automatic logic [LEN_W-1:0] rnd_length();
        if ($urandom_range(99) < 3)
            return LEN_W'($urandom_range(8191, 1));
        return LEN_W'($urandom_range(24, 1));
    endfunction

    // Random values for fields that the item kind ignores
    function automatic logic [ADDR_W-1:0] rnd_addr();
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rnd_word();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] rnd_len_any();
        return LEN_W'($urandom);
    endfunction

    task automatic plan_item(input mixer_item_t it);
        mixer_reply_t unused;
        if (it.kind == KIND_LOAD)
            word_loaded[it.load_address] = 1'b1;
        unused = mix_apply(PLAN_COPY, it);
        item_backlog.push_back(it);
    endtask

    // Queue one item; before a tick, load any word an active voice is about to read
    task automatic offer(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] la,
                         input logic [SAMPLE_W-1:0] lv, input logic [ADDR_W-1:0] ss,
                         input logic [LEN_W-1:0] sl);
        mixer_item_t it;
        mixer_item_t fix;
        int v;
        if (k == KIND_TICK)
        begin
            for (v = 0; v < VOICES; v++)
            begin
                if (voice_on[PLAN_COPY][v] && !word_loaded[voice_addr[PLAN_COPY][v]])
                begin
                    fix.kind         = KIND_LOAD;
                    fix.load_address = voice_addr[PLAN_COPY][v];
                    fix.load_value   = rnd_sample();
                    fix.sound_start  = rnd_addr();
                    fix.sound_length = rnd_len_any();
                    plan_item(fix);
                end
            end
        end
        it.kind         = k;
        it.load_address = la;
        it.load_value   = lv;
        it.sound_start  = ss;
        it.sound_length = sl;
        plan_item(it);
    endtask

    function automatic int sender_idle_pct();
        int phase;
        phase = (planned_total == 0) ? 0 : items_taken * 3 / planned_total;
        return (phase == 0) ? 21 : (phase == 1) ? 68 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        int phase;
        phase = (planned_total == 0) ? 0 : items_taken * 3 / planned_total;
        return (phase == 0) ? 68 : (phase == 1) ? 21 : 0;
    endfunction

    // Build the stimulus, release reset, then wait for the block to drain
    initial
    begin
        int pick;
        int n;
        int i;
        int v;
        logic [ADDR_W-1:0] base;

        // extremes and saturation in both directions
        offer(KIND_LOAD, 12'd0, 16'h7FFF, rnd_addr(), rnd_len_any());
        offer(KIND_LOAD, 12'd4095, 16'h8000, rnd_addr(), rnd_len_any());
        offer(KIND_LOAD, 12'd1, 16'hFFFF, rnd_addr(), rnd_len_any());
        offer(KIND_LOAD, 12'd2, 16'h5555, rnd_addr(), rnd_len_any());
        offer(KIND_LOAD, 12'd4094, 16'hAAAA, rnd_addr(), rnd_len_any());
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd0, 13'd2);
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd0, 13'd2);
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd4095, 13'd1);
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd4095, 13'd1);
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd4095, 13'd1);
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
        // zero length and the unused kind are ignored
        offer(KIND_QUEUE, 12'hFFF, 16'hFFFF, 12'hFFF, 13'd0);
        offer(KIND_UNUSED, 12'hFFF, 16'hFFFF, 12'hFFF, 13'h1FFF);
        // playback wraps past the memory end
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd4094, 13'd3);
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
        // longest lengths, beyond the memory size too
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd4095, 13'd4096);
        offer(KIND_QUEUE, rnd_addr(), rnd_word(), 12'd0, 13'h1FFF);
        offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());

        last_base = 12'd0;
        noise_items = 0;
        while (item_backlog.size() - noise_items < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                // load a run of consecutive words
                base = rnd_addr();
                last_base = base;
                n = $urandom_range(12, 1);
                for (i = 0; i < n; i++)
                    offer(KIND_LOAD, base + i[ADDR_W-1:0], rnd_sample(), rnd_addr(),
                          rnd_len_any());
            end
            else if (pick < 45)
            begin
                // queue a few sounds, mostly over freshly loaded words
                n = $urandom_range(3, 1);
                for (i = 0; i < n; i++)
                begin
                    base = ($urandom_range(99) < 60) ? last_base + ADDR_W'($urandom_range(4))
                                                     : rnd_addr();
                    offer(KIND_QUEUE, rnd_addr(), rnd_word(), base, rnd_length());
                end
            end
            else if (pick < 85)
            begin
                n = $urandom_range(8, 1);
                for (i = 0; i < n; i++)
                    offer(KIND_TICK, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
            end
            else if (pick < 92)
            begin
                // fill the table and overflow it
                n = 0;
                for (v = 0; v < VOICES; v++)
                    if (!voice_on[PLAN_COPY][v])
                        n++;
                n = n + $urandom_range(3, 1);
                for (i = 0; i < n; i++)
                    offer(KIND_QUEUE, rnd_addr(), rnd_word(), last_base,
                          LEN_W'($urandom_range(6, 1)));
            end
            else
            begin
                // noise: unused kind or zero-length request
                if ($urandom_range(1))
                    offer(KIND_UNUSED, rnd_addr(), rnd_word(), rnd_addr(), rnd_len_any());
                else
                    offer(KIND_QUEUE, rnd_addr(), rnd_word(), rnd_addr(), 13'd0);
                noise_items++;
            end
        end
        planned_total = item_backlog.size();

        // hold reset, then release it away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (item_backlog.size() != 0 || item_valid)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d ticks (%0d at a clamp limit), %0d sounds queued,",
                 items_taken, ticks_seen, clamps_seen, queued_seen);
        $display("%0d table-full replies, under three sender/receiver idle mixes", full_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Drive items; predict the reply of each one the block accepts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            items_taken <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predicted_replies.push_back(mix_apply(LIVE_COPY, offered_item));
                items_taken <= items_taken + 1;
            end
            if (!item_valid || item_ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    offered_item = item_backlog.pop_front();
                    item_valid   <= 1'b1;
                    kind         <= offered_item.kind;
                    load_address <= offered_item.load_address;
                    load_value   <= offered_item.load_value;
                    sound_start  <= offered_item.sound_start;
                    sound_length <= offered_item.sound_length;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, once for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && items_taken >= planned_total / 6)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end

    // Compare each delivered item against the oldest prediction
    always @(posedge clk)
    begin
        mixer_reply_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_replies.size() == 0)
            begin
                $display("%0t: result with nothing predicted (mixed_sample %0d)",
                         $time, mixed_sample);
                mismatches++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (mixed_sample !== want.mixed_sample)
                begin
                    $display("%0t: mixed_sample expected %0d, got %0d", $time,
                             $signed(want.mixed_sample), mixed_sample);
                    mismatches++;
                end
                if (sample_valid !== want.sample_valid)
                begin
                    $display("%0t: sample_valid expected %0b, got %0b", $time,
                             want.sample_valid, sample_valid);
                    mismatches++;
                end
                if (queue_accepted !== want.queue_accepted)
                begin
                    $display("%0t: queue_accepted expected %0b, got %0b", $time,
                             want.queue_accepted, queue_accepted);
                    mismatches++;
                end
                if (queue_full !== want.queue_full)
                begin
                    $display("%0t: queue_full expected %0b, got %0b", $time,
                             want.queue_full, queue_full);
                    mismatches++;
                end
                if (want.sample_valid)
                    ticks_seen++;
                if (want.sample_valid && (want.mixed_sample == 16'h7FFF
                                          || want.mixed_sample == 16'h8000))
                    clamps_seen++;
                if (want.queue_accepted)
                    queued_seen++;
                if (want.queue_full)
                    full_seen++;
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
        else
            quiet_cycles <= 0;
    end

endmodule

// ----- voice_slot_sample_mixer_unit.f -----
hw/rtl/vssm_pkg.sv
hw/rtl/voice_slot_sample_mixer_unit.sv
hw/rtl/vssm_checker.sv
bench/testbench.sv
